// File: rtl/buzz_pkg.sv
// shared types and constants for the buzzer burst pattern player
package buzz_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int LEVEL_W         = 4;
  localparam int TIME_W          = 16;
  localparam int COUNT_W         = 8;
  localparam int IN_DATA_W       = 40;
  localparam int OUT_DATA_W      = 8;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_ON   = 2'd1,
    PHASE_GAP  = 2'd2
  } phase_t;

  typedef enum logic {
    CMD_TICK    = 1'b0,
    CMD_ENQUEUE = 1'b1
  } command_t;

  // one queued pattern, on time in the low bits
  typedef struct packed {
    logic [COUNT_W-1:0] repeat_count;
    logic [TIME_W-1:0]  off_time;
    logic [TIME_W-1:0]  on_time;
  } pattern_t;

endpackage

// File: rtl/buzzer_burst_pattern_player_core.sv
// buzzer burst pattern player: pattern queue in memory and tick-driven burst sequencer
//
// Takes one item per clock cycle, enqueue or millisecond tick, and returns one
// result per item in the cycle after its transfer, from an output register. The
// input is stalled only while that register holds a result not yet taken.
// Patterns sit in a QUEUE_DEPTH-entry memory with a registered read port;
// the head entry is read ahead from the next read pointer, and an enqueue into
// the entry being read is forwarded, so a pop on the following tick sees it.
// No clearing pass is needed after reset. sound_enabled is written through
// the cfg channel, which is always ready.
module buzzer_burst_pattern_player_core #(
  parameter int QUEUE_DEPTH = buzz_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // on_time [15:0], off_time [31:16], repeat_count [39:32]
  input  logic [buzz_pkg::IN_DATA_W-1:0]  s_tdata,
  // command [0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // buzzer_on [0], dropped [1], queue_level [5:2], busy_res [6], zero [7]
  output logic [buzz_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);
  import buzz_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic sound_enabled;

  logic [PTR_W-1:0]   read_pointer, read_pointer_next;
  logic [PTR_W-1:0]   write_pointer, write_pointer_next;
  logic [CNT_W-1:0]   stored_count, stored_count_next;
  phase_t             phase, phase_next;
  logic [TIME_W-1:0]  ticks_left, ticks_left_next;
  logic [COUNT_W-1:0] bursts_left, bursts_left_next;
  logic [TIME_W-1:0]  on_length, on_length_next;
  logic [TIME_W-1:0]  gap_length, gap_length_next;

  pattern_t           mem [QUEUE_DEPTH];
  pattern_t           rd_data, fwd_data, head;
  logic               fwd_valid;
  logic               wr_en;
  pattern_t           wr_data;

  logic               accept;
  logic               is_tick;
  logic               dropped;
  logic [COUNT_W-1:0] bursts_dec;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign is_tick   = (s_tuser == CMD_TICK);
  assign wr_data   = pattern_t'(s_tdata);
  assign head      = fwd_valid ? fwd_data : rd_data;
  assign bursts_dec = bursts_left - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enabled <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      sound_enabled <= cfg_data;
    end
  end

  always_comb begin
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    stored_count_next  = stored_count;
    phase_next         = phase;
    ticks_left_next    = ticks_left;
    bursts_left_next   = bursts_left;
    on_length_next     = on_length;
    gap_length_next    = gap_length;
    wr_en              = 1'b0;
    dropped            = 1'b0;

    if (accept) begin
      if (!is_tick) begin
        if (stored_count >= CNT_W'(QUEUE_DEPTH)) begin
          dropped = 1'b1;
        end else begin
          wr_en              = 1'b1;
          write_pointer_next = (write_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                               : write_pointer + 1'b1;
          stored_count_next  = stored_count + 1'b1;
        end
      end else begin
        case (phase)
          PHASE_IDLE: begin
            if (stored_count != '0) begin
              read_pointer_next = (read_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                  : read_pointer + 1'b1;
              stored_count_next = stored_count - 1'b1;
              if (sound_enabled && head.repeat_count != '0) begin
                on_length_next   = head.on_time;
                gap_length_next  = head.off_time;
                bursts_left_next = head.repeat_count;
                phase_next       = PHASE_ON;
                ticks_left_next  = (head.on_time == '0) ? '0 : head.on_time - 1'b1;
              end
            end
          end
          PHASE_ON: begin
            if (ticks_left != '0) begin
              ticks_left_next = ticks_left - 1'b1;
            end else begin
              bursts_left_next = bursts_dec;
              if (bursts_dec == '0) begin
                phase_next      = PHASE_IDLE;
                ticks_left_next = '0;
              end else if (gap_length == '0) begin
                // no gap: next burst starts at once, buzzer stays on
                ticks_left_next = (on_length == '0) ? '0 : on_length - 1'b1;
              end else begin
                phase_next      = PHASE_GAP;
                ticks_left_next = gap_length - 1'b1;
              end
            end
          end
          PHASE_GAP: begin
            if (ticks_left != '0) begin
              ticks_left_next = ticks_left - 1'b1;
            end else begin
              phase_next      = PHASE_ON;
              ticks_left_next = (on_length == '0) ? '0 : on_length - 1'b1;
            end
          end
          default: begin
            phase_next = PHASE_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      stored_count  <= '0;
      phase         <= PHASE_IDLE;
      ticks_left    <= '0;
      bursts_left   <= '0;
      on_length     <= '0;
      gap_length    <= '0;
    end else begin
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      stored_count  <= stored_count_next;
      phase         <= phase_next;
      ticks_left    <= ticks_left_next;
      bursts_left   <= bursts_left_next;
      on_length     <= on_length_next;
      gap_length    <= gap_length_next;
    end
  end

  // pattern memory, read ahead at the next head address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_pointer] <= wr_data;
    end
    rd_data  <= mem[read_pointer_next];
    fwd_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en && (write_pointer == read_pointer_next);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {1'b0,
                  (phase_next != PHASE_IDLE),
                  LEVEL_W'(stored_count_next),
                  dropped,
                  (phase_next == PHASE_ON)};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored_count <= CNT_W'(QUEUE_DEPTH))
    else $error("stored count above queue depth");

  a_busy_has_bursts: assert property (@(posedge clk) disable iff (rst)
    (phase != PHASE_IDLE) |-> (bursts_left != '0))
    else $error("player active with no bursts left");

  a_on_implies_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> m_tdata[6])
    else $error("buzzer on while not busy");

  a_tick_not_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && is_tick) |=> (m_tvalid && !m_tdata[1]))
    else $error("tick reported as dropped");

endmodule

// File: tb/sv/tb_buzzer_burst_pattern_player_core.sv
// self-checking testbench for the buzzer burst pattern player core
module tb_buzzer_burst_pattern_player_core;
  import buzz_pkg::*;

  localparam int QDEPTH     = QUEUE_DEPTH_DEF;
  localparam int N_DIRECTED = 22;
  localparam int N_PHASES   = 5;

  typedef struct {
    command_t cmd;
    pattern_t pat;
  } buzz_item_t;

  // same bit order as m_tdata[6:0]
  typedef struct packed {
    logic       busy;
    logic [3:0] level;
    logic       dropped;
    logic       buzzer_on;
  } buzz_result_t;

  typedef struct {
    command_t cmd;
    int       on_t, off_t, cnt;
    bit       fixed;
    int       bz, drp, lvl, bsy;
  } plan_row_t;

  // cmd, on, off, count, fixed, buzzer_on, dropped, level, busy
  plan_row_t directed_plan [N_DIRECTED] = '{
    '{CMD_TICK,        0,     0,   0, 1, 0, 0, 0, 0},
    '{CMD_ENQUEUE,     0,     0,   1, 1, 0, 0, 1, 0},  // zero on time
    '{CMD_ENQUEUE,     2,     0,   2, 1, 0, 0, 2, 0},  // bursts back to back
    '{CMD_ENQUEUE,     1,     2,   2, 1, 0, 0, 3, 0},
    '{CMD_ENQUEUE, 65535, 65535,   0, 1, 0, 0, 4, 0},  // zero count, discarded
    '{CMD_ENQUEUE,     1,     1,   3, 1, 0, 0, 5, 0},
    '{CMD_ENQUEUE,     0,     5,   1, 1, 0, 0, 6, 0},  // gap never used
    '{CMD_ENQUEUE,     3,     0,   0, 1, 0, 0, 7, 0},
    '{CMD_ENQUEUE,     1,     0,   1, 1, 0, 0, 8, 0},
    '{CMD_ENQUEUE,     7,     7,   7, 1, 0, 1, 8, 0},  // queue full
    '{CMD_TICK,        0,     0,   0, 1, 1, 0, 7, 1},
    '{CMD_TICK,        0,     0,   0, 1, 0, 0, 7, 0},  // finishing tick pops nothing
    '{CMD_TICK,        0,     0,   0, 0, 0, 0, 0, 0},
    '{CMD_TICK,        0,     0,   0, 0, 0, 0, 0, 0},
    '{CMD_ENQUEUE,     2,     1,   1, 0, 0, 0, 0, 0},  // enqueue mid-burst
    '{CMD_TICK,        0,     0,   0, 0, 0, 0, 0, 0},
    '{CMD_TICK,        0,     0,   0, 0, 0, 0, 0, 0},
    '{CMD_TICK,        0,     0,   0, 0, 0, 0, 0, 0},
    '{CMD_TICK,        0,     0,   0, 0, 0, 0, 0, 0},
    '{CMD_TICK,        0,     0,   0, 0, 0, 0, 0, 0},
    '{CMD_TICK,        0,     0,   0, 0, 0, 0, 0, 0},
    '{CMD_TICK,        0,     0,   0, 0, 0, 0, 0, 0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_data = 1'b0;

  // player model state
  pattern_t    queue_mem [QDEPTH];
  int          rd_ptr = 0;
  int          wr_ptr = 0;
  int          q_level = 0;
  phase_t      phase = PHASE_IDLE;
  logic [15:0] ticks_left = '0;
  logic [15:0] on_len = '0;
  logic [15:0] gap_len = '0;
  logic [7:0]  bursts_left = '0;
  logic        sound_en = 1'b1;

  buzz_result_t expected_results [$];
  bit quiet_tail = 1'b0;
  bit long_hold_done = 1'b0;
  int n_items = 0;
  int n_enqueues = 0;
  int n_drops = 0;
  int n_played = 0;
  int n_checked = 0;
  int n_errors = 0;

  buzzer_burst_pattern_player_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // on_time [15:0], off_time [31:16], repeat_count [39:32]
    .s_tuser   (s_tuser),    // command [0]
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // buzzer_on [0], dropped [1], queue_level [5:2], busy [6]
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void begin_burst();
    phase = PHASE_ON;
    ticks_left = (on_len == 0) ? 16'd0 : on_len - 16'd1;
  endfunction

  function automatic buzz_result_t play_step(input buzz_item_t it);
    buzz_result_t r;
    pattern_t     p;
    r = '0;
    if (it.cmd == CMD_ENQUEUE) begin
      n_enqueues++;
      if (q_level >= QDEPTH) begin
        r.dropped = 1'b1;
        n_drops++;
      end else begin
        queue_mem[wr_ptr] = it.pat;
        wr_ptr = (wr_ptr + 1) % QDEPTH;
        q_level++;
      end
    end else begin
      case (phase)
        PHASE_IDLE: begin
          if (q_level != 0) begin
            p = queue_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % QDEPTH;
            q_level--;
            // muted or empty patterns leave at pop
            if (sound_en && p.repeat_count != 0) begin
              on_len = p.on_time;
              gap_len = p.off_time;
              bursts_left = p.repeat_count;
              begin_burst();
              n_played++;
            end
          end
        end
        PHASE_ON: begin
          if (ticks_left != 0) begin
            ticks_left--;
          end else begin
            bursts_left--;
            if (bursts_left == 0) begin
              phase = PHASE_IDLE;
              ticks_left = '0;
            end else if (gap_len == 0) begin
              begin_burst();
            end else begin
              phase = PHASE_GAP;
              ticks_left = gap_len - 16'd1;
            end
          end
        end
        default: begin
          if (ticks_left != 0) ticks_left--;
          else begin_burst();
        end
      endcase
    end
    r.buzzer_on = (phase == PHASE_ON);
    r.level = 4'(q_level);
    r.busy = (phase != PHASE_IDLE);
    return r;
  endfunction

  // mostly short patterns so the queue cycles; wide values ride on zero counts
  function automatic buzz_item_t pick_item();
    buzz_item_t it;
    int         sel;
    sel = $urandom_range(0, 99);
    it.cmd = ($urandom_range(0, 99) < 30) ? CMD_ENQUEUE : CMD_TICK;
    if (sel < 70) begin
      it.pat.on_time = 16'($urandom_range(0, 3));
      it.pat.off_time = 16'($urandom_range(0, 3));
      it.pat.repeat_count = 8'($urandom_range(0, 4));
    end else if (sel < 85) begin
      it.pat.on_time = 16'($urandom);
      it.pat.off_time = 16'($urandom);
      it.pat.repeat_count = '0;
    end else if (sel < 90) begin
      it.pat.on_time = 16'($urandom_range(0, 1));
      it.pat.off_time = 16'($urandom_range(0, 1));
      it.pat.repeat_count = 8'($urandom_range(0, 255));
    end else begin
      it.pat.on_time = 16'($urandom_range(0, 40));
      it.pat.off_time = 16'($urandom_range(0, 40));
      it.pat.repeat_count = 8'($urandom_range(1, 3));
    end
    return it;
  endfunction

  task automatic send_item(input buzz_item_t it, input bit fixed, input buzz_result_t fixed_res);
    buzz_result_t predicted;
    @(negedge clk);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.cmd;
    s_tdata <= it.pat;
    do @(posedge clk); while (!s_tready);
    predicted = play_step(it);
    expected_results.push_back(fixed ? fixed_res : predicted);
    n_items++;
  endtask

  // register writes only with no transfer in flight
  task automatic write_sound_enable(input logic value);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sound_en = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_errors++;
    end
  endtask

  // result side: random stalls, one long hold, field checks
  initial begin
    int           stall_left;
    buzz_result_t want;
    buzz_result_t got;
    stall_left = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (stall_left == 0 && !quiet_tail) begin
        if (!long_hold_done && n_checked >= 200) begin
          stall_left = 150;
          long_hold_done = 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 14);
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        n_checked++;
        if (expected_results.size() == 0) begin
          $error("unexpected result transfer: m_tdata=%h", m_tdata);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          got = m_tdata[6:0];
          check_field("buzzer_on", 4'(want.buzzer_on), 4'(got.buzzer_on));
          check_field("dropped", 4'(want.dropped), 4'(got.dropped));
          check_field("queue_level", want.level, got.level);
          check_field("busy_res", 4'(want.busy), 4'(got.busy));
          check_field("pad bit", 4'd0, 4'(m_tdata[7]));
        end
      end
    end
  end

  initial begin
    buzz_item_t   it;
    buzz_result_t fixed_res;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_plan[i]) begin
      it.cmd = directed_plan[i].cmd;
      it.pat.on_time = 16'(directed_plan[i].on_t);
      it.pat.off_time = 16'(directed_plan[i].off_t);
      it.pat.repeat_count = 8'(directed_plan[i].cnt);
      fixed_res.buzzer_on = 1'(directed_plan[i].bz);
      fixed_res.dropped = 1'(directed_plan[i].drp);
      fixed_res.level = 4'(directed_plan[i].lvl);
      fixed_res.busy = 1'(directed_plan[i].bsy);
      send_item(it, directed_plan[i].fixed, fixed_res);
    end

    // sound on, muted, on, muted, on; the muted phases start while a pattern may play
    for (int p = 0; p < N_PHASES; p++) begin
      write_sound_enable(p % 2 == 0);
      quiet_tail = (p == N_PHASES - 1);
      repeat ((p % 2 == 0) ? 220 : 100) send_item(pick_item(), 1'b0, '0);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("run: %0d items, %0d enqueues (%0d refused on a full queue), %0d patterns sounded",
             n_items, n_enqueues, n_drops, n_played);
    $display("run: %0d results checked across muted and unmuted phases, long output hold %0s",
             n_checked, long_hold_done ? "done" : "not reached");
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
